// File: rtl/fte_pkg.sv
// Shared types, constants and helpers of the FAT12 table engine.
// Has no dependencies; every other file of the block imports it.
package fte_pkg;

	localparam int TABLE_BYTES = 8192;
	localparam int BANK_DEPTH  = TABLE_BYTES / 2;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int BYTE_AW     = $clog2(TABLE_BYTES);
	localparam int CLU_W       = 12;
	localparam int CNT_W       = 13;

	localparam logic [CNT_W-1:0] MAX_ENTRIES = 13'd4096;
	localparam logic [CNT_W-1:0] FIRST_DATA  = 13'd2;

	localparam logic [CLU_W-1:0] ENT_FREE     = 12'h000;
	localparam logic [CLU_W-1:0] ENT_RESERVED = 12'h001;
	localparam logic [CLU_W-1:0] ENT_USED_MAX = 12'hff6;
	localparam logic [CLU_W-1:0] ENT_BAD      = 12'hff7;
	localparam logic [7:0]       NIBBLE_MASK  = 8'h0f;

	localparam logic [7:0]  SPC_RESET   = 8'd1;
	localparam logic [15:0] DSS_RESET   = 16'd33;
	localparam logic [12:0] COUNT_RESET = 13'd3072;

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_SCAN   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_SPC   = 2'd0,
		REG_DSS   = 2'd1,
		REG_COUNT = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		CLS_FREE     = 3'd0,
		CLS_USED     = 3'd1,
		CLS_BAD      = 3'd2,
		CLS_END      = 3'd3,
		CLS_RESERVED = 3'd4
	} entry_class_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [12:0]      byte_index;
		logic [7:0]       byte_value;
		logic [CLU_W-1:0] cluster;
	} req_t;

	typedef struct packed {
		logic [CLU_W-1:0] next_cluster;
		logic [2:0]       entry_class;
		logic [15:0]      next_sector;
		logic [CNT_W-1:0] free_total;
		logic [CNT_W-1:0] used_total;
		logic [CNT_W-1:0] bad_total;
		logic [CNT_W-1:0] end_total;
	} rsp_t;

	typedef struct packed {
		logic               en;
		logic [BYTE_AW-1:0] index;
		logic [7:0]         value;
	} mem_wr_t;

	function automatic entry_class_t class_of(input logic [CLU_W-1:0] e);
		entry_class_t k;
		if (e == ENT_FREE)
			k = CLS_FREE;
		else if (e == ENT_RESERVED)
			k = CLS_RESERVED;
		else if (e <= ENT_USED_MAX)
			k = CLS_USED;
		else if (e == ENT_BAD)
			k = CLS_BAD;
		else
			k = CLS_END;
		return k;
	endfunction

endpackage

// File: rtl/fte_table_mem.sv
// Packed FAT12 table storage: two byte banks (even and odd byte addresses)
// so both bytes of an entry come out in one read. Depends on fte_pkg.
module fte_table_mem
	import fte_pkg::*;
(
	input  logic             clk,
	input  mem_wr_t          wr,
	input  logic [CLU_W-1:0] rd_cluster,
	output logic [CLU_W-1:0] rd_entry
);

	logic [7:0] even_mem [BANK_DEPTH];
	logic [7:0] odd_mem  [BANK_DEPTH];

	logic [BYTE_AW-1:0] base;
	logic [BANK_AW-1:0] even_addr;
	logic [BANK_AW-1:0] odd_addr;
	logic [7:0]         even_s1;
	logic [7:0]         odd_s1;
	logic               base_odd_s1;
	logic               clu_odd_s1;
	logic [7:0]         lo_byte;
	logic [7:0]         hi_byte;

	assign base      = BYTE_AW'(rd_cluster) + BYTE_AW'(rd_cluster >> 1);
	assign odd_addr  = base[BYTE_AW-1:1];
	assign even_addr = base[BYTE_AW-1:1] + BANK_AW'(base[0]);

	always_ff @(posedge clk) begin
		if (wr.en && !wr.index[0])
			even_mem[wr.index[BYTE_AW-1:1]] <= wr.value;
		even_s1 <= even_mem[even_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.index[0])
			odd_mem[wr.index[BYTE_AW-1:1]] <= wr.value;
		odd_s1 <= odd_mem[odd_addr];
	end

	always_ff @(posedge clk) begin
		base_odd_s1 <= base[0];
		clu_odd_s1  <= rd_cluster[0];
	end

	assign lo_byte = base_odd_s1 ? odd_s1 : even_s1;
	assign hi_byte = base_odd_s1 ? even_s1 : odd_s1;

	always_comb begin
		if (clu_odd_s1)
			rd_entry = {hi_byte, lo_byte[7:4]};
		else
			rd_entry = {hi_byte[3:0] & NIBBLE_MASK[3:0], lo_byte};
	end

endmodule

// File: rtl/fat12_table_engine_top.sv
// Top level of the FAT12 table engine: request decode, lookup, scan walk,
// configuration registers and the response register. Depends on fte_pkg
// and fte_table_mem.
// Requests are served one at a time: a write or unused code goes straight to the done
// state, a lookup passes through the lookup state, and a scan walks clusters 2 to
// lim-1 (lim = min(entry_count, 4096)) one entry per cycle through the table read port.
// The next request is taken the cycle after the response loads.
// Reset clears control state and loads the register defaults; table
// contents stay undefined until written, so no clearing pass is run.
module fat12_table_engine_top
	import fte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	logic [7:0]       spc_q;
	logic [15:0]      dss_q;
	logic [12:0]      count_q;
	logic [CNT_W-1:0] scan_c_q;
	logic             pend_s1;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] bad_q;
	logic [CNT_W-1:0] end_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             accept;
	logic             issue_ok;
	logic             rsp_free;
	logic [CNT_W-1:0] lim;
	logic [CLU_W-1:0] rd_cluster;
	logic [CLU_W-1:0] entry;
	entry_class_t     cls;
	logic [15:0]      sector;
	mem_wr_t          wr;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign lim       = (count_q > MAX_ENTRIES) ? MAX_ENTRIES : count_q;
	assign issue_ok  = (scan_c_q < lim);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign rd_cluster = (state_q == ST_SCAN) ? scan_c_q[CLU_W-1:0] : req_data.cluster;

	assign wr.en    = accept && (req_data.func == FUNC_WRITE);
	assign wr.index = req_data.byte_index;
	assign wr.value = req_data.byte_value;

	fte_table_mem u_mem (
		.clk        (clk),
		.wr         (wr),
		.rd_cluster (rd_cluster),
		.rd_entry   (entry)
	);

	assign cls    = class_of(entry);
	assign sector = (16'(entry) - 16'd2) * 16'(spc_q) + dss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q   <= SPC_RESET;
			dss_q   <= DSS_RESET;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SPC:   spc_q   <= cfg_data[7:0];
				REG_DSS:   dss_q   <= cfg_data;
				REG_COUNT: count_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_s1  <= 1'b0;
			scan_c_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_data.func)
							FUNC_LOOKUP: state_q <= ST_LOOK;
							FUNC_SCAN: begin
								state_q  <= ST_SCAN;
								scan_c_q <= FIRST_DATA;
								pend_s1  <= 1'b0;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOOK: state_q <= ST_DONE;
				ST_SCAN: begin
					pend_s1 <= issue_ok;
					if (issue_ok)
						scan_c_q <= scan_c_q + 1'b1;
					else if (!pend_s1)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_q  <= '0;
				free_q <= '0;
				used_q <= '0;
				bad_q  <= '0;
				end_q  <= '0;
			end
			ST_LOOK: begin
				res_q <= '{
					next_cluster: entry,
					entry_class:  cls,
					next_sector:  (cls == CLS_USED) ? sector : 16'd0,
					free_total:   '0,
					used_total:   '0,
					bad_total:    '0,
					end_total:    '0
				};
			end
			ST_SCAN: begin
				if (pend_s1) begin
					case (cls)
						CLS_FREE: free_q <= free_q + 1'b1;
						CLS_USED: used_q <= used_q + 1'b1;
						CLS_BAD:  bad_q  <= bad_q + 1'b1;
						CLS_END:  end_q  <= end_q + 1'b1;
						default: ;
					endcase
				end else if (!issue_ok) begin
					res_q <= '{
						next_cluster: '0,
						entry_class:  '0,
						next_sector:  '0,
						free_total:   free_q,
						used_total:   used_q,
						bad_total:    bad_q,
						end_total:    end_q
					};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == ST_DONE && rsp_free)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free)
			rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_c_q <= MAX_ENTRIES && scan_c_q >= FIRST_DATA)
		else $error("scan cluster counter out of range");

	a_done_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_free) |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("finished result not handed to response register");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_LOOK) |-> !accept)
		else $error("request accepted while busy");

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for fat12_table_engine_top: table writes, entry lookups and scans
// are checked against an in-bench table image, with random gaps on both channels.
// Depends on fte_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb;
	import fte_pkg::*;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req_data  = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp_data;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	fat12_table_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// table image and register copies used to predict replies
	bit [7:0]    tbl_mem [TABLE_BYTES];
	logic [7:0]  sec_per_clu = SPC_RESET;
	logic [15:0] data_start  = DSS_RESET;
	logic [12:0] entry_cnt   = COUNT_RESET;

	// what the stimulus has already placed in the table, for legal reads only
	bit [7:0] plan_mem [TABLE_BYTES];
	bit       plan_set [TABLE_BYTES];

	req_t        request_q [$];
	rsp_t        reply_q [$];
	int unsigned issued     = 0;
	int unsigned answered   = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap   = 0;
	int unsigned stall_left = 0;
	bit          calm       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [11:0] fat_entry(input logic [11:0] c);
		logic [12:0] base;
		base = {1'b0, c} + {2'b00, c[11:1]};
		if (c[0])
			return {tbl_mem[base + 13'd1], tbl_mem[base][7:4]};
		return {tbl_mem[base + 13'd1][3:0], tbl_mem[base]};
	endfunction

	function automatic entry_class_t entry_kind(input logic [11:0] e);
		if (e == ENT_BAD)
			return CLS_BAD;
		if (e > ENT_BAD)
			return CLS_END;
		if (e > ENT_RESERVED)
			return CLS_USED;
		if (e == ENT_RESERVED)
			return CLS_RESERVED;
		return CLS_FREE;
	endfunction

	function automatic rsp_t fat_reply(input req_t req);
		rsp_t         r;
		logic [11:0]  e;
		entry_class_t k;
		logic [31:0]  s;
		int           lim;
		int           n_free, n_used, n_bad, n_end;
		r = '0;
		n_free = 0;
		n_used = 0;
		n_bad = 0;
		n_end = 0;
		case (req.func)
			FUNC_WRITE: begin
				tbl_mem[req.byte_index] = req.byte_value;
			end
			FUNC_LOOKUP: begin
				e = fat_entry(req.cluster);
				k = entry_kind(e);
				r.next_cluster = e;
				r.entry_class = k;
				if (k == CLS_USED) begin
					s = (32'(e) - 32'd2) * 32'(sec_per_clu) + 32'(data_start);
					r.next_sector = s[15:0];
				end
			end
			FUNC_SCAN: begin
				lim = (entry_cnt > MAX_ENTRIES) ? int'(MAX_ENTRIES) : int'(entry_cnt);
				for (int c = 2; c < lim; c++) begin
					case (entry_kind(fat_entry(12'(c))))
						CLS_FREE: n_free++;
						CLS_USED: n_used++;
						CLS_BAD:  n_bad++;
						CLS_END:  n_end++;
						default:  ;
					endcase
				end
				r.free_total = 13'(n_free);
				r.used_total = 13'(n_used);
				r.bad_total = 13'(n_bad);
				r.end_total = 13'(n_end);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'hf7;
			3: return 8'h7f;
			4: return 8'h01;
			5: return 8'h10;
			6: return 8'h0f;
			7: return 8'hf0;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_entry();
		case ($urandom_range(0, 7))
			0: return ENT_FREE;
			1: return ENT_RESERVED;
			2: return ENT_BAD;
			3: return 12'($urandom_range(12'hff8, 12'hfff));
			4: return 12'h002;
			5: return ENT_USED_MAX;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_cluster();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return 12'($urandom_range(0, 63));
		if (roll == 4)
			return 12'($urandom_range(4032, 4095));
		return 12'($urandom);
	endfunction

	function automatic req_t noise_req(input func_t f);
		req_t r;
		r.func = f;
		r.byte_index = 13'($urandom);
		r.byte_value = 8'($urandom);
		r.cluster = 12'($urandom);
		return r;
	endfunction

	task automatic queue_write(input logic [12:0] idx, input logic [7:0] val);
		req_t r;
		r = noise_req(FUNC_WRITE);
		r.byte_index = idx;
		r.byte_value = val;
		request_q.push_back(r);
		plan_mem[idx] = val;
		plan_set[idx] = 1'b1;
	endtask

	task automatic queue_lookup(input logic [11:0] c);
		req_t        r;
		logic [12:0] base;
		base = {1'b0, c} + {2'b00, c[11:1]};
		for (int b = 0; b < 2; b++)
			if (!plan_set[base + 13'(b)])
				queue_write(base + 13'(b), pick_byte());
		r = noise_req(FUNC_LOOKUP);
		r.cluster = c;
		request_q.push_back(r);
	endtask

	// store one entry, then read it back
	task automatic queue_link(input logic [11:0] c, input logic [11:0] e);
		logic [12:0] base;
		base = {1'b0, c} + {2'b00, c[11:1]};
		if (c[0]) begin
			queue_write(base, {e[3:0], plan_mem[base][3:0]});
			queue_write(base + 13'd1, e[11:4]);
		end else begin
			queue_write(base, e[7:0]);
			queue_write(base + 13'd1, {plan_mem[base + 13'd1][7:4], e[11:8]});
		end
		queue_lookup(c);
	endtask

	task automatic queue_scan(input int lim);
		int last;
		int hi;
		if (lim > 2) begin
			last = lim - 1;
			hi = last + last / 2 + 1;
			for (int b = 3; b <= hi; b++)
				if (!plan_set[b])
					queue_write(13'(b), pick_byte());
		end
		request_q.push_back(noise_req(FUNC_SCAN));
	endtask

	task automatic queue_random(input int n, input int scan_pct, input int lim);
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < scan_pct)
				queue_scan(lim);
			else if (roll < scan_pct + 3)
				request_q.push_back(noise_req(FUNC_NONE));
			else if (roll < scan_pct + 45)
				queue_lookup(pick_cluster());
			else if (roll < scan_pct + 60)
				queue_link(pick_cluster(), pick_entry());
			else
				queue_write(13'($urandom), pick_byte());
		end
	endtask

	task automatic wait_idle();
		while (request_q.size() != 0 || issued != answered)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SPC:   sec_per_clu = val[7:0];
			REG_DSS:   data_start = val;
			REG_COUNT: entry_cnt = val[12:0];
			default:   ;
		endcase
	endtask

	task automatic run_phase(input logic [15:0] spc_v, input logic [15:0] dss_v,
			input logic [15:0] cnt_v, input int n, input int scan_pct, input bit quiet);
		int lim;
		calm = quiet;
		set_reg(REG_SPC, spc_v);
		set_reg(REG_DSS, dss_v);
		set_reg(REG_COUNT, cnt_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		lim = (cnt_v[12:0] > MAX_ENTRIES) ? int'(MAX_ENTRIES) : int'(cnt_v[12:0]);
		queue_random(n, scan_pct, lim);
		wait_idle();
	endtask

	task automatic cmp_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			if (mismatches < 40)
				$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_reply(input rsp_t got);
		rsp_t want;
		if (reply_q.size() == 0) begin
			if (mismatches < 40)
				$error("reply with no request outstanding: %h", got);
			mismatches++;
		end else begin
			want = reply_q.pop_front();
			answered++;
			cmp_field("next_cluster", 16'(want.next_cluster), 16'(got.next_cluster));
			cmp_field("entry_class", 16'(want.entry_class), 16'(got.entry_class));
			cmp_field("next_sector", want.next_sector, got.next_sector);
			cmp_field("free_total", 16'(want.free_total), 16'(got.free_total));
			cmp_field("used_total", 16'(want.used_total), 16'(got.used_total));
			cmp_field("bad_total", 16'(want.bad_total), 16'(got.bad_total));
			cmp_field("end_total", 16'(want.end_total), 16'(got.end_total));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			send_gap <= 0;
		end else begin
			if (req_valid && !req_stall)
				reply_q.push_back(fat_reply(req_data));
			if (!req_valid || !req_stall) begin
				if (send_gap != 0 || request_q.size() == 0) begin
					req_valid <= 1'b0;
					if (send_gap != 0)
						send_gap <= send_gap - 1;
				end else begin
					req_valid <= 1'b1;
					req_data <= request_q.pop_front();
					issued++;
					send_gap <= pick_gap();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_reply(rsp_data);
			if (stall_left != 0) begin
				rsp_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				rsp_stall <= 1'b0;
				stall_left <= pick_gap();
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		queue_link(12'd0, ENT_FREE);
		queue_link(12'd1, ENT_RESERVED);
		queue_link(12'd2, ENT_BAD);
		queue_link(12'd3, 12'hff8);
		queue_link(12'd4, 12'h002);
		queue_link(12'd5, ENT_USED_MAX);
		queue_link(12'd6, 12'hfff);
		queue_link(12'd4095, 12'h5a5);
		queue_write(13'h1fff, 8'hff);
		request_q.push_back(noise_req(FUNC_NONE));
		queue_random(180, 3, int'(COUNT_RESET));
		wait_idle();

		run_phase(16'd128, 16'hffff, 16'd2, 180, 15, 1'b0);
		set_reg(REG_NONE, 16'hffff);
		run_phase(16'd255, 16'd12345, 16'd0, 150, 15, 1'b1);
		run_phase(16'd3, 16'd0, 16'd100, 200, 10, 1'b0);
		run_phase(16'd0, 16'd40000, 16'd3, 150, 15, 1'b0);
		run_phase(16'd2, 16'd33, 16'd4096, 150, 2, 1'b0);
		run_phase(16'hff80, 16'hfff0, 16'hffff, 150, 2, 1'b1);
		run_phase(16'd8, 16'd500, 16'd1500, 200, 6, 1'b0);
		run_phase(16'd1, 16'd33, 16'd37, 180, 12, 1'b0);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("[fat12_table_engine_top] OK");
		else
			$display("[fat12_table_engine_top] ERROR");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("[fat12_table_engine_top] ERROR");
		$finish;
	end

endmodule
